[sv/occlusion_count_reducer_macros.svh]
// Assertion helpers for the top-level file of this block.
`ifndef OCCLUSION_COUNT_REDUCER_MACROS_SVH
`define OCCLUSION_COUNT_REDUCER_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, muted during reset.
`define OCC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising edge, muted during reset.
`define OCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/occ_pkg.sv]
package occ_pkg;

  localparam int unsigned WORD_W         = 64;
  localparam int unsigned NARROW_W       = 32;
  localparam int unsigned COUNT_BITS_DEF = 63;
  localparam int unsigned CFG_IDX_W      = 3;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDE_RESULTS        = 3'd0,
    CFG_REPORT_AVAILABILITY = 3'd1,
    CFG_ALLOW_PARTIAL       = 3'd2,
    CFG_ACCUMULATE_MODE     = 3'd3,
    CFG_BINARY_MODE         = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic wide_results;
    logic report_availability;
    logic allow_partial;
    logic accumulate_mode;
    logic binary_mode;
  } cfg_t;

  // One counter pair after the input register.
  typedef struct packed {
    logic [WORD_W-1:0] term;
    logic              pair_ok;
    logic              last_counter;
    logic              last_slot;
    logic [WORD_W-1:0] prior_result;
    logic              prior_available;
  } pair_t;

  typedef struct packed {
    logic [WORD_W-1:0] result_value;
    logic              result_written;
    logic              available;
    logic              available_written;
    logic              slot_ready;
    logic              batch_ready;
  } result_t;

endpackage

[sv/occlusion_count_reducer.sv]
// Occlusion count reducer: folds runs of begin/end pass-counter pairs into
// one query-slot result each.
// Input channel: one beat per counter pair, taken when in_valid_i is high and
// in_stall_o is low. A beat with last_counter_i high closes the slot and
// produces exactly one result beat; other beats produce none.
// Output channel: a result beat is taken when out_valid_o is high and
// out_stall_i is low; the payload holds steady while stalled.
// Configuration: cfg_valid_i with cfg_ready_o (always high) writes bit 0 of
// cfg_data_i to the register picked by cfg_index_i; unknown indexes are
// ignored. Write only while no slot is in flight.
// A closing beat passes through the input register and then the result
// register. Throughput: one pair per cycle, except that a closing pair waits
// while a stalled result holds the result register.
// While a result waits under stall, pairs that do not close a slot still flow
// in; a closing pair waits in the input register until the result is taken.
// Reset clears both valid flags, the running sum and all configuration, and
// sets the slot-valid and batch-ready flags.
`include "occlusion_count_reducer_macros.svh"

module occlusion_count_reducer #(
  parameter int unsigned COUNT_BITS = occ_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [occ_pkg::WORD_W-1:0]    begin_word_i,
  input  logic [occ_pkg::WORD_W-1:0]    end_word_i,
  input  logic                          last_counter_i,
  input  logic                          last_slot_i,
  input  logic [occ_pkg::WORD_W-1:0]    prior_result_i,
  input  logic                          prior_available_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [occ_pkg::WORD_W-1:0]    result_value_o,
  output logic                          result_written_o,
  output logic                          available_o,
  output logic                          available_written_o,
  output logic                          slot_ready_o,
  output logic                          batch_ready_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [occ_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic                          cfg_data_i
);

  occ_pkg::cfg_t    cfg_q, cfg_d;
  occ_pkg::pair_t   pair;
  occ_pkg::result_t result_next, result_out;
  logic             pair_valid, space, advance, load;

  // Configuration registers take every beat; the block only samples them while items
  // are in flight, and the user must keep writes away then; the block does not enforce this.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        occ_pkg::CFG_WIDE_RESULTS:        cfg_d.wide_results        = cfg_data_i;
        occ_pkg::CFG_REPORT_AVAILABILITY: cfg_d.report_availability = cfg_data_i;
        occ_pkg::CFG_ALLOW_PARTIAL:       cfg_d.allow_partial       = cfg_data_i;
        occ_pkg::CFG_ACCUMULATE_MODE:     cfg_d.accumulate_mode     = cfg_data_i;
        occ_pkg::CFG_BINARY_MODE:         cfg_d.binary_mode         = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // A pair moves on when it closes no slot, or when the result register
  // is free or being emptied in this cycle.
  assign advance = pair_valid & (~pair.last_counter | space);
  assign load    = advance & pair.last_counter;

  occ_pair_stage #(
    .COUNT_BITS(COUNT_BITS)
  ) u_pair_stage (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .begin_word_i     (begin_word_i),
    .end_word_i       (end_word_i),
    .last_counter_i   (last_counter_i),
    .last_slot_i      (last_slot_i),
    .prior_result_i   (prior_result_i),
    .prior_available_i(prior_available_i),
    .advance_i        (advance),
    .pair_valid_o     (pair_valid),
    .pair_o           (pair)
  );

  occ_slot_reduce u_slot_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .pair_i  (pair),
    .fire_i  (advance),
    .result_o(result_next)
  );

  occ_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .result_i   (result_next),
    .space_o    (space),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .result_o   (result_out)
  );

  assign result_value_o      = result_out.result_value;
  assign result_written_o    = result_out.result_written;
  assign available_o         = result_out.available;
  assign available_written_o = result_out.available_written;
  assign slot_ready_o        = result_out.slot_ready;
  assign batch_ready_o       = result_out.batch_ready;

  // A slot whose result is withheld must report a zero value.
  `OCC_ASSERT_SAME(a_unwritten_is_zero, clk_i, rst_ni, out_valid_o && !result_written_o, result_value_o == '0, "unwritten result carries a value")
  // Availability is only reported for a ready slot with reporting enabled.
  `OCC_ASSERT_SAME(a_avail_consistent, clk_i, rst_ni, out_valid_o && available_o, available_written_o && slot_ready_o, "availability without a ready slot")
  // The batch cannot be ready while the current slot is not.
  `OCC_ASSERT_SAME(a_batch_implies_slot, clk_i, rst_ni, out_valid_o && batch_ready_o, slot_ready_o, "batch ready with slot not ready")
  // A closing pair that leaves the input register lands in the result register.
  `OCC_ASSERT_NEXT(a_load_shows, clk_i, rst_ni, load, out_valid_o, "loaded result not presented")

endmodule

[sv/occ_pair_stage.sv]
module occ_pair_stage #(
  parameter int unsigned COUNT_BITS = occ_pkg::COUNT_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [occ_pkg::WORD_W-1:0] begin_word_i,
  input  logic [occ_pkg::WORD_W-1:0] end_word_i,
  input  logic                      last_counter_i,
  input  logic                      last_slot_i,
  input  logic [occ_pkg::WORD_W-1:0] prior_result_i,
  input  logic                      prior_available_i,
  input  logic                      advance_i,
  output logic                      pair_valid_o,
  output occ_pkg::pair_t            pair_o
);

  localparam int unsigned PadW = occ_pkg::WORD_W - COUNT_BITS;

  logic                       valid_q, valid_d;
  occ_pkg::pair_t             pair_q, pair_d;
  logic                       accept;
  logic [occ_pkg::WORD_W-1:0] begin_count, end_count;
  logic                       ok;

  assign in_stall_o   = valid_q & ~advance_i;
  assign accept       = in_valid_i & ~in_stall_o;
  assign pair_valid_o = valid_q;
  assign pair_o       = pair_q;

  // The difference is formed ahead of the register so the next stage
  // only has the accumulation left to do.
  assign begin_count = {{PadW{1'b0}}, begin_word_i[COUNT_BITS-1:0]};
  assign end_count   = {{PadW{1'b0}}, end_word_i[COUNT_BITS-1:0]};
  assign ok          = begin_word_i[occ_pkg::WORD_W-1] & end_word_i[occ_pkg::WORD_W-1];

  always_comb begin
    pair_d                 = pair_q;
    valid_d                = valid_q;
    if (accept) begin
      pair_d.term            = ok ? (end_count - begin_count) : '0;
      pair_d.pair_ok         = ok;
      pair_d.last_counter    = last_counter_i;
      pair_d.last_slot       = last_slot_i;
      pair_d.prior_result    = prior_result_i;
      pair_d.prior_available = prior_available_i;
      valid_d                = 1'b1;
    end else if (advance_i) begin
      valid_d                = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pair_q <= pair_d;
  end

endmodule

[sv/occ_slot_reduce.sv]
module occ_slot_reduce (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  occ_pkg::cfg_t   cfg_i,
  input  occ_pkg::pair_t  pair_i,
  input  logic            fire_i,
  output occ_pkg::result_t result_o
);

  localparam int unsigned W  = occ_pkg::WORD_W;
  localparam int unsigned NW = occ_pkg::NARROW_W;

  logic [W-1:0] running_sum_q, running_sum_d;
  logic         slot_all_valid_q, slot_all_valid_d;
  logic         batch_all_ready_q, batch_all_ready_d;

  logic [W-1:0] sum_next, prior_fit, acc_add, total, fitted;
  logic         slot_valid, written, ready, avail_w;

  assign sum_next   = running_sum_q + pair_i.term;
  assign slot_valid = slot_all_valid_q & pair_i.pair_ok;

  assign prior_fit = cfg_i.wide_results ? pair_i.prior_result
                                        : {{(W-NW){1'b0}}, pair_i.prior_result[NW-1:0]};
  assign acc_add   = cfg_i.accumulate_mode ? prior_fit : '0;

  // Wrapping at 32 bits commutes with the add, so the running sum is truncated only at the end.
  assign total  = sum_next + acc_add;
  assign fitted = cfg_i.wide_results ? total : {{(W-NW){1'b0}}, total[NW-1:0]};

  assign written = slot_valid | cfg_i.allow_partial;
  assign avail_w = cfg_i.report_availability;
  assign ready   = slot_valid &
                   (~(avail_w & cfg_i.accumulate_mode) | pair_i.prior_available);

  always_comb begin
    result_o                   = '0;
    if (written) begin
      result_o.result_value    = cfg_i.binary_mode ? {{(W-1){1'b0}}, (fitted != '0)}
                                                   : fitted;
    end
    result_o.result_written    = written;
    result_o.available         = avail_w & ready;
    result_o.available_written = avail_w;
    result_o.slot_ready        = ready;
    result_o.batch_ready       = batch_all_ready_q & ready;
  end

  always_comb begin
    running_sum_d     = running_sum_q;
    slot_all_valid_d  = slot_all_valid_q;
    batch_all_ready_d = batch_all_ready_q;
    if (fire_i) begin
      if (pair_i.last_counter) begin
        running_sum_d     = '0;
        slot_all_valid_d  = 1'b1;
        batch_all_ready_d = pair_i.last_slot | (batch_all_ready_q & ready);
      end else begin
        running_sum_d     = sum_next;
        slot_all_valid_d  = slot_valid;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_sum_q     <= '0;
      slot_all_valid_q  <= 1'b1;
      batch_all_ready_q <= 1'b1;
    end else begin
      running_sum_q     <= running_sum_d;
      slot_all_valid_q  <= slot_all_valid_d;
      batch_all_ready_q <= batch_all_ready_d;
    end
  end

endmodule

[sv/occ_out_reg.sv]
module occ_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  occ_pkg::result_t result_i,
  output logic             space_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output occ_pkg::result_t result_o
);

  logic             valid_q, valid_d;
  occ_pkg::result_t data_q, data_d;
  logic             take;

  assign take        = valid_q & ~out_stall_i;
  assign space_o     = ~valid_q | take;
  assign out_valid_o = valid_q;
  assign result_o    = data_q;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (load_i) begin
      valid_d = 1'b1;
      data_d  = result_i;
    end else if (take) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule
